// File: hdl/ttc_pkg.sv
// Shared types and constants for the transition timestamp capture block.
// No dependencies; used by every module in hdl/.
package ttc_pkg;

	localparam int CHANNELS_DEFAULT = 2;
	localparam int QUEUE_DEPTH      = 4;

	localparam logic [15:0] OVERHEAD_RESET = 16'd3;
	localparam logic [15:0] CAPACITY_RESET = 16'd1500;

	// Register index as taken from paddr[2].
	localparam logic REG_OVERHEAD = 1'b0;
	localparam logic REG_CAPACITY = 1'b1;

	localparam logic [31:0] LIMIT_1B = 32'h0000_00ff;
	localparam logic [31:0] LIMIT_2B = 32'h0000_ffff;
	localparam logic [31:0] LIMIT_3B = 32'h00ff_ffff;

	// One record passed from the front to the back: an event or the end marker.
	typedef struct packed {
		logic        is_end;
		logic [7:0]  header;
		logic [31:0] stamp;
		logic [1:0]  tlen;
	} rec_t;

endpackage

// File: hdl/ttc_front.sv
// Front part: takes sample items, tracks phase, levels, interval and byte budget,
// and pushes one record per event or end of capture. Depends on ttc_pkg.
module ttc_front #(
	parameter int CHANNELS = ttc_pkg::CHANNELS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        levels,
	input  logic              stop_request,
	input  logic [15:0]       overhead_ticks,
	input  logic [15:0]       capacity_bytes,
	input  logic              queue_full,
	output logic              push,
	output ttc_pkg::rec_t     push_rec
);

	typedef enum logic [1:0] {
		PH_BASELINE = 2'd0,
		PH_WAIT     = 2'd1,
		PH_ARMED    = 2'd2,
		PH_ENDED    = 2'd3
	} phase_t;

	localparam logic [7:0] MASK = 8'((1 << CHANNELS) - 1);

	phase_t       phase_q;
	logic [7:0]   known_q;
	logic [31:0]  counter_q;
	logic [15:0]  used_q;

	logic         accept;
	logic [7:0]   lv;
	logic [7:0]   diff;
	logic [2:0]   ch;
	logic         val;
	logic [31:0]  stamp;
	logic [1:0]   tlen;
	logic [17:0]  need;
	logic         budget_full;
	logic         stop_now;
	logic         event_now;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign lv       = levels & MASK;
	assign diff     = (lv ^ known_q) & MASK;

	// Lowest-numbered changed channel wins.
	always_comb begin
		ch = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (diff[i]) begin
				ch = 3'(i);
			end
		end
	end

	assign val   = lv[ch];
	assign stamp = (phase_q == PH_WAIT) ? 32'd0 : counter_q;

	always_comb begin
		if (stamp > ttc_pkg::LIMIT_3B) begin
			tlen = 2'd3;
		end else if (stamp > ttc_pkg::LIMIT_2B) begin
			tlen = 2'd2;
		end else if (stamp > ttc_pkg::LIMIT_1B) begin
			tlen = 2'd1;
		end else begin
			tlen = 2'd0;
		end
	end

	assign need        = {2'b00, used_q} + {16'd0, tlen} + 18'd2;
	assign budget_full = need >= {2'b00, capacity_bytes};
	assign stop_now    = (phase_q == PH_ARMED) && stop_request;
	assign event_now   = ((phase_q == PH_WAIT) || (phase_q == PH_ARMED)) && (diff != 8'd0);

	always_comb begin
		push_rec.is_end = stop_now || budget_full;
		push_rec.header = {2'b00, tlen, val, ch};
		push_rec.stamp  = stamp;
		push_rec.tlen   = tlen;
		push            = accept && (stop_now || event_now);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_BASELINE;
			known_q   <= 8'd0;
			counter_q <= 32'd0;
			used_q    <= 16'd0;
		end else if (accept) begin
			case (phase_q)
				PH_BASELINE: begin
					known_q   <= lv;
					counter_q <= counter_q + 32'd1;
					phase_q   <= PH_WAIT;
				end
				PH_WAIT, PH_ARMED: begin
					if (stop_now) begin
						phase_q <= PH_ENDED;
					end else if (event_now) begin
						known_q[ch] <= val;
						counter_q   <= {16'd0, overhead_ticks};
						if (budget_full) begin
							phase_q <= PH_ENDED;
						end else begin
							phase_q <= PH_ARMED;
							used_q  <= need[15:0];
						end
					end else begin
						counter_q <= counter_q + 32'd1;
					end
				end
				default: begin
					phase_q <= PH_ENDED;
				end
			endcase
		end
	end

endmodule

// File: hdl/ttc_queue.sv
// Short record queue between the front and the back.
// Depends on ttc_pkg for the record type.
module ttc_queue #(
	parameter int DEPTH = ttc_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ttc_pkg::rec_t push_rec,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output ttc_pkg::rec_t head_rec
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	ttc_pkg::rec_t     mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = count_q == CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_rec   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: hdl/ttc_back.sv
// Back part: walks the head record byte by byte into the output register.
// Depends on ttc_pkg for the record type.
module ttc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  ttc_pkg::rec_t head_rec,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          last_byte,
	output logic          capture_ended
);

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       end_q;
	logic       load;
	logic [7:0] sel_byte;
	logic       sel_last;

	assign load = head_valid && (!valid_q || out_ready);

	always_comb begin
		case (idx_q)
			3'd0:    sel_byte = head_rec.is_end ? 8'd0 : head_rec.header;
			3'd1:    sel_byte = head_rec.stamp[7:0];
			3'd2:    sel_byte = head_rec.stamp[15:8];
			3'd3:    sel_byte = head_rec.stamp[23:16];
			3'd4:    sel_byte = head_rec.stamp[31:24];
			default: sel_byte = 8'd0;
		endcase
		sel_last = head_rec.is_end || (idx_q == ({1'b0, head_rec.tlen} + 3'd1));
	end

	assign pop = load && sel_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 3'd0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= sel_last ? 3'd0 : idx_q + 3'd1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= sel_byte;
			last_q <= sel_last;
			end_q  <= head_rec.is_end;
		end
	end

	assign out_valid     = valid_q;
	assign out_byte      = byte_q;
	assign last_byte     = last_q;
	assign capture_ended = end_q;

endmodule

// File: hdl/transition_timestamp_capture.sv
// Transition timestamp capture: one sample item per cycle in, record bytes out.
// Throughput: one item per cycle, one output byte per cycle while out_ready is high;
// an event yields 2 to 5 bytes; each record passes the queue, then the output register.
// Input stalls only while the record queue is full, which the serializer drains.
// Reset: asynchronous, restores register defaults, clears phase, interval and budget.
module transition_timestamp_capture #(
	parameter int CHANNELS = ttc_pkg::CHANNELS_DEFAULT,
	parameter int QDEPTH   = ttc_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  levels,
	input  logic        stop_request,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_byte,
	output logic        capture_ended
);

	logic [15:0]   overhead_q;
	logic [15:0]   capacity_q;
	logic          push;
	ttc_pkg::rec_t push_rec;
	logic          queue_full;
	logic          pop;
	logic          head_valid;
	ttc_pkg::rec_t head_rec;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overhead_q <= ttc_pkg::OVERHEAD_RESET;
			capacity_q <= ttc_pkg::CAPACITY_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				ttc_pkg::REG_OVERHEAD: overhead_q <= pwdata[15:0];
				ttc_pkg::REG_CAPACITY: capacity_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ttc_pkg::REG_OVERHEAD: prdata = {16'd0, overhead_q};
			ttc_pkg::REG_CAPACITY: prdata = {16'd0, capacity_q};
			default:               prdata = 32'd0;
		endcase
	end

	ttc_front #(.CHANNELS(CHANNELS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.levels         (levels),
		.stop_request   (stop_request),
		.overhead_ticks (overhead_q),
		.capacity_bytes (capacity_q),
		.queue_full     (queue_full),
		.push           (push),
		.push_rec       (push_rec)
	);

	ttc_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	ttc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_rec      (head_rec),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.last_byte     (last_byte),
		.capture_ended (capture_ended)
	);

	// The end marker is a single zero byte that closes its record.
	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && capture_ended |-> last_byte && (out_byte == 8'd0))
		else $error("end marker malformed");

	// Nothing follows the end marker until reset.
	a_end_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && capture_ended |=> !out_valid)
		else $error("output after end marker");

endmodule
